// ----- src/moie_pkg.sv -----
// Package for the memory-operand instruction executor.
// Holds the opcode constants, the word width and the request/response beat types.
// No dependencies.
package moie_pkg;

	localparam int WORD_BITS = 32;
	localparam int DEST_BITS = 10;
	localparam int OP_BITS   = 4;

	localparam logic [OP_BITS-1:0] OP_ADD    = 4'd0;
	localparam logic [OP_BITS-1:0] OP_MUL    = 4'd1;
	localparam logic [OP_BITS-1:0] OP_LE     = 4'd2;
	localparam logic [OP_BITS-1:0] OP_NEG    = 4'd3;
	localparam logic [OP_BITS-1:0] OP_ASSIGN = 4'd4;
	localparam logic [OP_BITS-1:0] OP_JMP    = 4'd5;
	localparam logic [OP_BITS-1:0] OP_JZ     = 4'd6;
	localparam logic [OP_BITS-1:0] OP_READ   = 4'd7;
	localparam logic [OP_BITS-1:0] OP_WRITE  = 4'd8;
	localparam logic [OP_BITS-1:0] OP_HALT   = 4'd9;

	typedef struct packed {
		logic [OP_BITS-1:0]          op;
		logic                        first_is_address;
		logic signed [WORD_BITS-1:0] first_source;
		logic                        second_is_address;
		logic signed [WORD_BITS-1:0] second_source;
		logic [DEST_BITS-1:0]        destination;
		logic signed [WORD_BITS-1:0] entered_value;
	} req_t;

	typedef struct packed {
		logic [DEST_BITS-1:0]        next_pc;
		logic                        halted;
		logic                        jump_fault;
		logic                        emit_valid;
		logic signed [WORD_BITS-1:0] emitted_value;
	} rsp_t;

endpackage

// ----- src/moie_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// Read data updates only when re is high; a read during a write returns old data.
// No dependencies.
module moie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- src/memory_operand_instruction_executor.sv -----
// Memory-operand instruction executor: top level.
// Depends on moie_pkg and moie_ram.
//
// Usage:
// - req channel (req_valid/req_stall/req) takes one instruction per beat; rsp
//   channel (rsp_valid/rsp_stall/rsp) returns one result beat per instruction,
//   in order.
// - Flow: an accepted beat waits in the execute register; its result is
//   registered as it advances. Throughput is one instruction per cycle unless
//   rsp_stall blocks; the operand reads use the two read ports of the data RAM
//   at acceptance, and the executing write-back is forwarded to the next one.
// - Reset: PC and halt flag clear at once; then a clearing pass writes zero to
//   every data word, one per cycle, with req_stall high.
// - When rsp_stall holds the result register, one more instruction can sit in
//   the execute register; after that req_stall rises until the result is taken.
// - DATA_WORDS and PROGRAM_WORDS must be powers of two; data addresses use the
//   low address bits, negative addresses wrap.
// - After a halt every instruction is ignored and halted reads 1.
module memory_operand_instruction_executor import moie_pkg::*; #(
	parameter int DATA_WORDS    = 1024,
	parameter int PROGRAM_WORDS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DATA_WORDS);
	localparam int PW = $clog2(PROGRAM_WORDS);

	logic                 clr_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 valid_s1;
	req_t                 item_s1;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic [PW-1:0]        pc_q;
	logic                 halt_q;
	logic                 fwd_valid_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [WORD_BITS-1:0] fwd_data_q;

	logic                 req_accept;
	logic                 adv;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] rdata_a;
	logic [WORD_BITS-1:0] rdata_b;
	logic [WORD_BITS-1:0] op_a;
	logic [WORD_BITS-1:0] op_b;
	logic [WORD_BITS-1:0] dest_w;
	logic [PW-1:0]        target;
	logic [PW-1:0]        pc_inc;
	logic [PW-1:0]        pc_d;
	logic                 halt_d;
	logic                 fault;
	logic                 emit;
	logic [WORD_BITS-1:0] emit_val;
	logic                 we_ex;
	logic [WORD_BITS-1:0] wval;
	logic [WORD_BITS-1:0] pc_w;

	assign adv        = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = clr_q || (valid_s1 && !adv);
	assign req_accept = req_valid && !req_stall;

	assign ram_we    = clr_q || (adv && we_ex);
	assign ram_waddr = clr_q ? clr_cnt_q : dest_w[AW-1:0];
	assign ram_wdata = clr_q ? '0 : wval;

	moie_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DATA_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (req_accept),
		.raddr_a(req.first_source[AW-1:0]),
		.raddr_b(req.second_source[AW-1:0]),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// operand select with forwarding of the write made as this beat entered
	always_comb begin
		if (!item_s1.first_is_address) begin
			op_a = item_s1.first_source;
		end else if (fwd_valid_q && fwd_addr_q == item_s1.first_source[AW-1:0]) begin
			op_a = fwd_data_q;
		end else begin
			op_a = rdata_a;
		end
		if (!item_s1.second_is_address) begin
			op_b = item_s1.second_source;
		end else if (fwd_valid_q && fwd_addr_q == item_s1.second_source[AW-1:0]) begin
			op_b = fwd_data_q;
		end else begin
			op_b = rdata_b;
		end
	end

	assign dest_w = {{(WORD_BITS-DEST_BITS){1'b0}}, item_s1.destination};
	assign target = dest_w[PW-1:0];
	assign pc_inc = (pc_q == PW'(PROGRAM_WORDS-1)) ? '0 : pc_q + PW'(1);

	always_comb begin
		pc_d     = pc_q;
		halt_d   = halt_q;
		fault    = 1'b0;
		emit     = 1'b0;
		emit_val = '0;
		we_ex    = 1'b0;
		wval     = '0;
		if (!halt_q) begin
			case (item_s1.op)
				OP_ADD: begin
					we_ex = 1'b1;
					wval  = op_a + op_b;
					pc_d  = pc_inc;
				end
				OP_MUL: begin
					we_ex = 1'b1;
					wval  = op_a * op_b;
					pc_d  = pc_inc;
				end
				OP_LE: begin
					we_ex = 1'b1;
					wval  = ($signed(op_a) <= $signed(op_b)) ? WORD_BITS'(1) : '0;
					pc_d  = pc_inc;
				end
				OP_NEG: begin
					we_ex = 1'b1;
					wval  = '0 - op_a;
					pc_d  = pc_inc;
				end
				OP_ASSIGN: begin
					we_ex = 1'b1;
					wval  = op_a;
					pc_d  = pc_inc;
				end
				OP_JMP: begin
					if (target == pc_q) begin
						fault = 1'b1;
					end else begin
						pc_d = target;
					end
				end
				OP_JZ: begin
					if (target == pc_q) begin
						fault = 1'b1;
					end else if (op_a == '0) begin
						pc_d = target;
					end else begin
						pc_d = pc_inc;
					end
				end
				OP_READ: begin
					we_ex = 1'b1;
					wval  = item_s1.entered_value;
					pc_d  = pc_inc;
				end
				OP_WRITE: begin
					emit     = 1'b1;
					emit_val = op_a;
					pc_d     = pc_inc;
				end
				OP_HALT: begin
					halt_d = 1'b1;
				end
				default: begin
					pc_d = pc_inc;
				end
			endcase
		end
	end

	assign pc_w = {{(WORD_BITS-PW){1'b0}}, pc_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(DATA_WORDS-1)) begin
					clr_q <= 1'b0;
				end
			end
			if (req_accept) begin
				valid_s1    <= 1'b1;
				fwd_valid_q <= ram_we;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
				pc_q        <= pc_d;
				halt_q      <= halt_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			item_s1    <= req;
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
		if (adv) begin
			rsp_q.next_pc       <= pc_w[DEST_BITS-1:0];
			rsp_q.halted        <= halt_d;
			rsp_q.jump_fault    <= fault;
			rsp_q.emit_valid    <= emit;
			rsp_q.emitted_value <= emit_val;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> req_stall)
		else $error("beat accepted during clearing pass");

	a_write_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_q) |-> adv)
		else $error("data write without retiring instruction");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && rsp_stall) |-> req_stall)
		else $error("input taken while execute register blocked");

endmodule
